@@ rtl/rua_pkg.sv @@
// Shared constants, types and command/status bundles of the replica unit allocator.
package rua_pkg;

  // Array geometry; UNITS_PER_DISK must stay a power of two (scan wraps by masking)
  localparam int unsigned NUM_DISKS      = 8;
  localparam int unsigned UNITS_PER_DISK = 1024;
  localparam int unsigned REPLICAS       = 3;
  localparam int unsigned MAX_UNITS      = 8;

  localparam int unsigned DISK_W  = $clog2(NUM_DISKS);
  localparam int unsigned POS_W   = $clog2(UNITS_PER_DISK);
  localparam int unsigned DEPTH   = NUM_DISKS * UNITS_PER_DISK;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);

  // Field widths of the stream payloads
  localparam int unsigned OWNER_W   = 16;
  localparam int unsigned TAG_W     = 5;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PART_W    = 11;
  localparam int unsigned REP_W     = 2;
  localparam int unsigned DISKNUM_W = 4;
  localparam int unsigned UPOS_W    = 11;
  localparam int unsigned PROD_W    = TAG_W + PART_W;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FULL
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;   // input stage open
    logic load;       // transfer accepted: latch request
    logic clr_write;  // write one zero entry of the clearing pass
    logic rd;         // read the unit under the scan pointer
    logic claim;      // write owner, emit result, advance scan
    logic skip;       // unit taken: advance scan
    logic emit_err;   // emit disk-full result
    logic next_rep;   // move on to the next replica disk
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;   // clearing pass at last entry
    logic req_zero;   // offered request asks for no units
    logic unit_free;  // read unit has no owner
    logic found_meet; // one more claim completes the replica
    logic step_last;  // current unit closes the lap
    logic rep_last;   // working on the final replica
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

@@ rtl/rua_ctrl.sv @@
// Sequencer of the replica unit allocator: clearing pass, scan loop and result issue.
module rua_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rua_pkg::sts_t sts_i,
  output rua_pkg::cmd_t cmd_o
);

  rua_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rua_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rua_pkg::ST_CLEAR: begin
        if (sts_i.clr_done) state_d = rua_pkg::ST_IDLE;
      end
      rua_pkg::ST_IDLE: begin
        if (in_valid_i && !sts_i.req_zero) state_d = rua_pkg::ST_READ;
      end
      rua_pkg::ST_READ: begin
        state_d = rua_pkg::ST_CHECK;
      end
      rua_pkg::ST_CHECK: begin
        if (sts_i.unit_free) begin
          if (sts_i.out_free) begin
            if (sts_i.found_meet) begin
              state_d = sts_i.rep_last ? rua_pkg::ST_IDLE : rua_pkg::ST_READ;
            end else if (sts_i.step_last) begin
              state_d = rua_pkg::ST_FULL;
            end else begin
              state_d = rua_pkg::ST_READ;
            end
          end
        end else begin
          state_d = sts_i.step_last ? rua_pkg::ST_FULL : rua_pkg::ST_READ;
        end
      end
      rua_pkg::ST_FULL: begin
        if (sts_i.out_free) begin
          state_d = sts_i.rep_last ? rua_pkg::ST_IDLE : rua_pkg::ST_READ;
        end
      end
      default: state_d = rua_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      rua_pkg::ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
      end
      rua_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i;
      end
      rua_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      rua_pkg::ST_CHECK: begin
        if (sts_i.unit_free) begin
          if (sts_i.out_free) begin
            cmd_o.claim    = 1'b1;
            cmd_o.next_rep = sts_i.found_meet && !sts_i.rep_last;
          end
        end else begin
          cmd_o.skip = 1'b1;
        end
      end
      rua_pkg::ST_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          cmd_o.next_rep = !sts_i.rep_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  // A result is only issued into a free output register
  a_claim_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.claim |-> sts_i.out_free)
    else $error("claim issued while output register busy");

  a_err_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_err |-> sts_i.out_free)
    else $error("disk-full result issued while output register busy");

  // Only a unit seen free is claimed
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.claim |-> sts_i.unit_free)
    else $error("claim of an owned unit");

  // No request enters during the clearing pass
  a_clear_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_write |-> !cmd_o.in_ready)
    else $error("input open during clearing pass");

endmodule

@@ rtl/rua_dpath.sv @@
// Datapath of the replica unit allocator: request registers, ownership store, scan
// counters and output register.
module rua_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rua_pkg::cmd_t                   cmd_i,
  output rua_pkg::sts_t                   sts_o,
  input  logic [rua_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  logic                            cfg_valid_i,
  input  logic [rua_pkg::PART_W-1:0]      cfg_data_i,
  input  logic                            m_tready_i,
  output logic                            m_tvalid_o,
  output logic [rua_pkg::M_TDATA_W-1:0]   m_tdata_o,
  output logic                            m_tlast_o,
  output logic                            m_tuser_o
);

  localparam int unsigned DISK_LAST = rua_pkg::NUM_DISKS - 1;

  // Request fields of the offered transfer
  logic [rua_pkg::OWNER_W-1:0] in_owner;
  logic [rua_pkg::TAG_W-1:0]   in_tag;
  logic [rua_pkg::CNT_W-1:0]   in_cnt;
  logic [rua_pkg::CNT_W-1:0]   in_cnt_sat;
  logic [rua_pkg::TAG_W-1:0]   tag_m1;
  logic [rua_pkg::PROD_W-1:0]  start_prod;
  logic [rua_pkg::POS_W-1:0]   start_d;

  logic [rua_pkg::PART_W-1:0]  part_q;
  logic [rua_pkg::DISK_W-1:0]  rot_q;
  logic [rua_pkg::OWNER_W-1:0] owner_q;
  logic [rua_pkg::CNT_W-1:0]   count_q;
  logic [rua_pkg::POS_W-1:0]   start_q;
  logic [rua_pkg::DISK_W-1:0]  disk_q;
  logic [rua_pkg::REP_W-1:0]   rep_q;
  logic [rua_pkg::POS_W-1:0]   pos_q;
  logic [rua_pkg::POS_W-1:0]   step_q;
  logic [rua_pkg::CNT_W-1:0]   found_q;
  logic [rua_pkg::ADDR_W-1:0]  clr_q;

  logic [rua_pkg::OWNER_W-1:0] mem [rua_pkg::DEPTH];
  logic [rua_pkg::OWNER_W-1:0] rd_q;
  logic                        mem_we;
  logic [rua_pkg::ADDR_W-1:0]  mem_waddr;
  logic [rua_pkg::OWNER_W-1:0] mem_wdata;
  logic [rua_pkg::ADDR_W-1:0]  scan_addr;
  logic [rua_pkg::DISK_W-1:0]  disk_nxt;
  logic [rua_pkg::DISK_W-1:0]  rot_nxt;

  logic                          m_valid_q;
  logic [rua_pkg::REP_W-1:0]     o_rep_q;
  logic [rua_pkg::DISKNUM_W-1:0] o_disk_q;
  logic [rua_pkg::UPOS_W-1:0]    o_pos_q;
  logic                          o_last_q;
  logic                          o_full_q;

  // Unpack and condition the request
  assign in_owner   = s_tdata_i[rua_pkg::OWNER_W-1:0];
  assign in_tag     = s_tdata_i[rua_pkg::OWNER_W +: rua_pkg::TAG_W];
  assign in_cnt     = s_tdata_i[rua_pkg::OWNER_W + rua_pkg::TAG_W +: rua_pkg::CNT_W];
  assign in_cnt_sat = (in_cnt > rua_pkg::CNT_W'(rua_pkg::MAX_UNITS))
                      ? rua_pkg::CNT_W'(rua_pkg::MAX_UNITS) : in_cnt;
  assign tag_m1     = rua_pkg::TAG_W'(in_tag - rua_pkg::TAG_W'(1));
  assign start_prod = rua_pkg::PROD_W'(tag_m1) * rua_pkg::PROD_W'(part_q);
  assign start_d    = (in_tag == '0) ? '0 : start_prod[rua_pkg::POS_W-1:0];

  // Wrapping disk steps
  assign disk_nxt = (disk_q == rua_pkg::DISK_W'(DISK_LAST))
                    ? '0 : rua_pkg::DISK_W'(disk_q + rua_pkg::DISK_W'(1));
  assign rot_nxt  = (rot_q == rua_pkg::DISK_W'(DISK_LAST))
                    ? '0 : rua_pkg::DISK_W'(rot_q + rua_pkg::DISK_W'(1));

  // Hold the partition length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
    end else if (cfg_valid_i) begin
      part_q <= cfg_data_i;
    end
  end

  // Rotation, replica and scan control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q   <= '0;
      count_q <= '0;
      rep_q   <= '0;
      found_q <= '0;
      step_q  <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.clr_write) clr_q <= rua_pkg::ADDR_W'(clr_q + rua_pkg::ADDR_W'(1));
      if (cmd_i.load) begin
        rot_q   <= rot_nxt;
        count_q <= in_cnt_sat;
        rep_q   <= '0;
        found_q <= '0;
        step_q  <= '0;
      end else if (cmd_i.next_rep) begin
        rep_q   <= rua_pkg::REP_W'(rep_q + rua_pkg::REP_W'(1));
        found_q <= '0;
        step_q  <= '0;
      end else if (cmd_i.claim || cmd_i.skip) begin
        step_q <= rua_pkg::POS_W'(step_q + rua_pkg::POS_W'(1));
        if (cmd_i.claim) found_q <= rua_pkg::CNT_W'(found_q + rua_pkg::CNT_W'(1));
      end
    end
  end

  // Request payload and scan pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      owner_q <= in_owner;
      start_q <= start_d;
      pos_q   <= start_d;
      disk_q  <= rot_q;
    end else if (cmd_i.next_rep) begin
      pos_q  <= start_q;
      disk_q <= disk_nxt;
    end else if (cmd_i.claim || cmd_i.skip) begin
      pos_q <= rua_pkg::POS_W'(pos_q + rua_pkg::POS_W'(1));
    end
  end

  // Ownership store: clearing pass or claim writes, scan reads
  assign scan_addr = {disk_q, pos_q};
  assign mem_we    = cmd_i.clr_write || cmd_i.claim;
  assign mem_waddr = cmd_i.clr_write ? clr_q : scan_addr;
  assign mem_wdata = cmd_i.clr_write ? '0 : owner_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.rd) rd_q <= mem[scan_addr];
  end

  // Status
  assign sts_o.clr_done   = (clr_q == rua_pkg::ADDR_W'(rua_pkg::DEPTH - 1));
  assign sts_o.req_zero   = (in_cnt == '0);
  assign sts_o.unit_free  = (rd_q == '0);
  assign sts_o.found_meet = (rua_pkg::CNT_W'(found_q + rua_pkg::CNT_W'(1)) == count_q);
  assign sts_o.step_last  = (step_q == rua_pkg::POS_W'(rua_pkg::UNITS_PER_DISK - 1));
  assign sts_o.rep_last   = (rep_q == rua_pkg::REP_W'(rua_pkg::REPLICAS - 1));
  assign sts_o.out_free   = !m_valid_q || m_tready_i;

  // Output register: load a result, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.claim || cmd_i.emit_err) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.claim || cmd_i.emit_err) begin
      o_rep_q  <= rua_pkg::REP_W'(rep_q + rua_pkg::REP_W'(1));
      o_disk_q <= rua_pkg::DISKNUM_W'(rua_pkg::DISKNUM_W'(disk_q) + rua_pkg::DISKNUM_W'(1));
      o_pos_q  <= cmd_i.emit_err ? '0
                  : rua_pkg::UPOS_W'(rua_pkg::UPOS_W'(pos_q) + rua_pkg::UPOS_W'(1));
      o_last_q <= sts_o.rep_last && (cmd_i.emit_err || sts_o.found_meet);
      o_full_q <= cmd_i.emit_err;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {(rua_pkg::M_TDATA_W - rua_pkg::REP_W - rua_pkg::DISKNUM_W
                        - rua_pkg::UPOS_W)'(0), o_pos_q, o_disk_q, o_rep_q};
  assign m_tlast_o  = o_last_q;
  assign m_tuser_o  = o_full_q;

  // Claims never run past the requested count
  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= count_q)
    else $error("more units claimed than requested");

  // A disk-full result never carries a unit position
  a_err_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && o_full_q |-> o_pos_q == '0)
    else $error("disk-full result with a unit position");

  // The clearing pass finishes before the first request is accepted
  a_load_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !cmd_i.clr_write && clr_q == '0)
    else $error("request accepted before clearing pass wrapped");

endmodule

@@ rtl/replica_unit_allocator.sv @@
// Top level of the replica unit allocator: stream ports, controller and datapath.
//
// After reset the block first zeroes its ownership store, one entry per cycle, over
// all NUM_DISKS*UNITS_PER_DISK = 8192 entries; s_axis_tready stays low during that
// pass, while partition-length writes are taken at any time. A request then claims
// its units on three disks in rotation. The scan reads the store through one
// registered port and visits each unit by a read, then a check and claim; a disk-full
// result is issued in a step of its own. One request is worked at a time; results
// wait in an output register and the scan stalls only while that register is held.
module replica_unit_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] owner_id, [20:16] tag, [24:21] unit_count, [31:25] zero
  input  logic [rua_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] replica_number, [5:2] disk_number, [16:6] unit_position, [23:17] zero
  output logic [rua_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,   // last_of_request
  output logic                          m_axis_tuser,   // disk_full
  // Partition length register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rua_pkg::PART_W-1:0]    cfg_data_i
);

  rua_pkg::cmd_t cmd;
  rua_pkg::sts_t sts;

  rua_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rua_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .m_tuser_o   (m_axis_tuser)
  );

  // Input opens only between requests; register writes are always taken
  assign s_axis_tready = cmd.in_ready;
  assign cfg_ready_o   = 1'b1;

endmodule

@@ test/tb.sv @@
// Self-checking testbench of the replica unit allocator: directed table and random traffic.
`timescale 1ns / 1ps

module tb;
  import rua_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 50000;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned HOLD_AFTER     = 30;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RANDOM_ITEMS   = 45;
  localparam int unsigned BATCH_MAX      = REPLICAS * MAX_UNITS;

  typedef struct packed {
    logic [REP_W-1:0]     replica;
    logic [DISKNUM_W-1:0] disk;
    logic [UPOS_W-1:0]    unit_pos;
    logic                 last;
    logic                 full;
  } unit_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [OWNER_W-1:0] owner;
    logic [TAG_W-1:0]   tag;
    logic [CNT_W-1:0]   count;
    logic [PART_W-1:0]  cfg_val;
    logic               typed;
    unit_result_t       exp;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [PART_W-1:0]    cfg_data_i;

  // Predictor state: unit owners, rotation counter and partition length
  bit   [OWNER_W-1:0]   owner_map [DEPTH];
  int unsigned          rot_count;
  int unsigned          part_len;
  unit_result_t         claim_batch [BATCH_MAX];
  int unsigned          claim_cnt;
  unit_result_t         claims_due [$];

  // Typed expectation for the first result of the item on the bus
  logic                 typed_on;
  unit_result_t         typed_first;

  // Run bookkeeping
  int unsigned          mismatches;
  int unsigned          items_in;
  int unsigned          results_seen;
  int unsigned          full_expected;
  int unsigned          cfg_writes;
  int unsigned          stall_cycles;
  bit                   calm;

  stim_row_t            directed_rows [$];

  replica_unit_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [S_TDATA_W-1:0] pack_request(input logic [OWNER_W-1:0] owner,
                                                         input logic [TAG_W-1:0] tag,
                                                         input logic [CNT_W-1:0] count);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[OWNER_W-1:0]              = owner;
    word[OWNER_W +: TAG_W]         = tag;
    word[OWNER_W + TAG_W +: CNT_W] = count;
    return word;
  endfunction

  function automatic stim_row_t req(input logic [OWNER_W-1:0] owner,
                                    input logic [TAG_W-1:0] tag,
                                    input logic [CNT_W-1:0] count);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_REQ;
    r.owner = owner;
    r.tag   = tag;
    r.count = count;
    return r;
  endfunction

  function automatic stim_row_t req_exp(input logic [OWNER_W-1:0] owner,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [CNT_W-1:0] count,
                                        input int unsigned rep, input int unsigned disk,
                                        input int unsigned pos, input bit full);
    stim_row_t r;
    r = req(owner, tag, count);
    r.typed        = 1'b1;
    r.exp.replica  = rep[REP_W-1:0];
    r.exp.disk     = disk[DISKNUM_W-1:0];
    r.exp.unit_pos = pos[UPOS_W-1:0];
    r.exp.full     = full;
    return r;
  endfunction

  function automatic stim_row_t cfg(input logic [PART_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.cfg_val = value;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Claim units for one request on three rotated disks; fill claim_batch in output order
  task automatic predict_claims(input logic [OWNER_W-1:0] owner, input logic [TAG_W-1:0] tag,
                                input logic [CNT_W-1:0] count);
    int unsigned base;
    int unsigned need;
    int unsigned start;
    int unsigned disk;
    int unsigned found;
    int unsigned pos;
    int unsigned step;
    int unsigned addr;
    base      = rot_count;
    rot_count = (rot_count + 1) % NUM_DISKS;
    claim_cnt = 0;
    need      = (32'(count) > MAX_UNITS) ? MAX_UNITS : 32'(count);
    if (need == 0) return;
    start = (tag == 0) ? 0 : (((32'(tag) - 1) * part_len) % UNITS_PER_DISK);
    for (int rep = 0; rep < REPLICAS; rep++) begin
      disk  = (base + rep) % NUM_DISKS;
      found = 0;
      pos   = start;
      for (step = 0; step < UNITS_PER_DISK && found < need; step++) begin
        addr = disk * UNITS_PER_DISK + pos;
        if (owner_map[addr] == 0) begin
          owner_map[addr] = owner;
          claim_batch[claim_cnt] = '{replica: REP_W'(rep + 1), disk: DISKNUM_W'(disk + 1),
                                     unit_pos: UPOS_W'(pos + 1), last: 1'b0, full: 1'b0};
          claim_cnt++;
          found++;
        end
        pos = (pos + 1) % UNITS_PER_DISK;
      end
      // Short lap: one error result closes the replica
      if (found < need) begin
        claim_batch[claim_cnt] = '{replica: REP_W'(rep + 1), disk: DISKNUM_W'(disk + 1),
                                   unit_pos: '0, last: 1'b0, full: 1'b1};
        claim_cnt++;
        full_expected++;
      end
    end
    claim_batch[claim_cnt - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d, t=%0t)",
             what, got, want, results_seen, $realtime);
  endtask

  // Check result transfers, track register writes, predict on request transfers
  always @(posedge clk_i) begin
    unit_result_t got;
    unit_result_t want;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        results_seen++;
        got.replica  = m_axis_tdata[REP_W-1:0];
        got.disk     = m_axis_tdata[REP_W +: DISKNUM_W];
        got.unit_pos = m_axis_tdata[REP_W + DISKNUM_W +: UPOS_W];
        got.last     = m_axis_tlast;
        got.full     = m_axis_tuser;
        if (claims_due.size() == 0) begin
          report_mismatch("result with nothing pending, unit", 32'(got.unit_pos), 0);
        end else begin
          want = claims_due.pop_front();
          if (got.replica != want.replica)
            report_mismatch("replica_number", 32'(got.replica), 32'(want.replica));
          if (got.disk != want.disk)
            report_mismatch("disk_number", 32'(got.disk), 32'(want.disk));
          if (got.unit_pos != want.unit_pos)
            report_mismatch("unit_position", 32'(got.unit_pos), 32'(want.unit_pos));
          if (got.last != want.last)
            report_mismatch("last_of_request", 32'(got.last), 32'(want.last));
          if (got.full != want.full)
            report_mismatch("disk_full", 32'(got.full), 32'(want.full));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved    = 1'b1;
        part_len = 32'(cfg_data_i);
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        items_in++;
        predict_claims(s_axis_tdata[OWNER_W-1:0], s_axis_tdata[OWNER_W +: TAG_W],
                       s_axis_tdata[OWNER_W + TAG_W +: CNT_W]);
        if (typed_on && claim_cnt > 0) begin
          claim_batch[0].replica  = typed_first.replica;
          claim_batch[0].disk     = typed_first.disk;
          claim_batch[0].unit_pos = typed_first.unit_pos;
          claim_batch[0].full     = typed_first.full;
        end
        for (int k = 0; k < claim_cnt; k++) claims_due.insert(claims_due.size(), claim_batch[k]);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // End the run when nothing has moved for too long
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("Watchdog: no transfer for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, claims_due.size());
    $display("Verification failed");
    $finish;
  end

  // Result sink: random back-pressure, one long hold-off, calm stretches
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (!hold_done && items_in >= HOLD_AFTER) begin
        hold_done     = 1'b1;
        hold_left     = HOLD_CYCLES - 1;
        m_axis_tready = 1'b0;
      end else if (calm) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= 33);
      end
    end
  end

  // Offer one request, first idling at random while not calm; starts and ends at a falling edge
  task automatic send_request(input logic [S_TDATA_W-1:0] word, input logic typed,
                              input unit_result_t exp);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    typed_on      = typed;
    typed_first   = exp;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop the request valid, wait for every pending result, then let the block go idle
  task automatic settle_block();
    s_axis_tvalid = 1'b0;
    typed_on      = 1'b0;
    while (claims_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_partition(input logic [PART_W-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    stim_row_t   row;
    logic [OWNER_W-1:0] owner;
    logic [TAG_W-1:0]   tag;
    logic [CNT_W-1:0]   count;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    typed_on      = 1'b0;
    typed_first   = '0;
    rot_count     = 0;
    part_len      = 0;
    claim_cnt     = 0;
    mismatches    = 0;
    items_in      = 0;
    results_seen  = 0;
    full_expected = 0;
    cfg_writes    = 0;
    stall_cycles  = 0;
    calm          = 1'b0;

    // Directed table; partition length starts at its reset value of zero
    add_row(req_exp(16'hFFFF,  1,  1, 1, 1, 1, 1'b0)); // empty store
    add_row(req_exp(16'h0001, 16,  8, 1, 2, 2, 1'b0)); // unit 1 of disk 2 taken
    add_row(req    (16'h0000,  0, 15));  // owner zero, tag zero, saturated count
    add_row(req    (16'h1234, 31,  0));  // zero count: only rotation advances
    add_row(req    (16'hABCD,  0,  4));  // reclaim units left free by owner zero
    add_row(cfg    (11'd2047));          // partition beyond range
    add_row(req    (16'h8000, 31,  8));  // tag above sixteen
    add_row(req    (16'h7FFF, 16,  9));
    add_row(req    (16'h00FF,  2,  1));
    add_row(cfg    (11'd1024));          // top of range: every start wraps to 0
    add_row(req    (16'hFF00, 16,  8));
    add_row(req    (16'h5555,  1, 15));
    add_row(cfg    (11'd1));
    add_row(req    (16'hAAAA,  5,  7));
    add_row(req    (16'h3C3C, 16,  3));
    add_row(req    (16'hC3C3, 17,  2));
    add_row(cfg    (11'd0));
    add_row(req    (16'h0F0F,  8,  5));
    add_row(req    (16'hF0F0, 31, 14));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle_block();
        write_partition(row.cfg_val);
      end else begin
        send_request(pack_request(row.owner, row.tag, row.count), row.typed, row.exp);
      end
    end

    // Random phases at different partition lengths; the middle one runs without idling
    for (int phase = 0; phase < 3; phase++) begin
      settle_block();
      case (phase)
        0:       write_partition(PART_W'($urandom_range(0, 2047)));
        1:       write_partition(PART_W'($urandom_range(1, 1024)));
        default: write_partition(PART_W'($urandom_range(0, 63)));
      endcase
      calm = (phase == 1);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if ($urandom_range(99) < 85) begin
          owner = OWNER_W'($urandom_range(1, 65535));
          tag   = TAG_W'($urandom_range(1, 16));
          count = CNT_W'($urandom_range(1, MAX_UNITS));
        end else begin
          owner = OWNER_W'($urandom_range(0, 65535));
          tag   = TAG_W'($urandom_range(0, 31));
          count = CNT_W'($urandom_range(0, 15));
        end
        send_request(pack_request(owner, tag, count), 1'b0, '0);
      end
      calm = 1'b0;
    end

    // Drain and let the tail settle
    settle_block();

    $display("Run covered %0d requests and %0d checked results, %0d of them disk-full,",
             items_in, results_seen, full_expected);
    $display("over %0d partition-length writes and a long sink hold-off with input stalled.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
